// File: hdl/ntids_pkg.sv
// ntids_pkg: operation and status codes shared by the name table block
// no dependencies

package ntids_pkg;

  // request operation, carried in tuser of the request beat
  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  // result status, carried in tuser of the result beat
  typedef enum logic [2:0] {
    ST_CREATED  = 3'd0,
    ST_EXISTS   = 3'd1,
    ST_DELETED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FOUND    = 3'd4,
    ST_FULL     = 3'd5,
    ST_LIST     = 3'd6,
    ST_EMPTY    = 3'd7
  } status_e;

  localparam int unsigned NameW = 64;

endpackage

// File: hdl/name_table_insert_delete_search.sv
// name_table_insert_delete_search: compact table of up to ENTRIES 64-bit names
// depends on ntids_pkg (op and status codes, name width)

// A request beat carries an operation in tuser and a name in tdata. Create,
// delete and search walk the stored names one per cycle through the single
// read port of the name memory before their one result beat appears; a
// delete that moves the last name into the freed slot adds a read and a
// write of that name. A list request gives one result beat per stored name,
// each held while the result side stalls, with tlast on the final one, or a
// single empty beat. The block takes one request at a time: tready is high
// only while no request is in progress and its results are delivered. The
// memory needs no clearing pass; only names from slots below the count are
// used.

module name_table_insert_delete_search #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [63:0] name
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] op
  // result side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [63:0] entry_name
  output logic [2:0]  m_axis_tuser_o,   // [2:0] status
  output logic        m_axis_tlast_o    // last
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned IdxW = $clog2(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_MOVE_RD,
    S_MOVE_WR,
    S_LIST_WAIT,
    S_OUT
  } state_e;

  state_e                     state_q;
  ntids_pkg::op_e             op_q;
  logic [ntids_pkg::NameW-1:0] key_q;
  logic [CntW-1:0]            count_q;
  logic [CntW-1:0]            idx_q;
  logic                       pend_q;
  logic                       hit_q;
  logic [IdxW-1:0]            hit_idx_q;
  logic                       out_valid_q;
  ntids_pkg::status_e         out_status_q;
  logic [ntids_pkg::NameW-1:0] out_name_q;
  logic                       out_last_q;

  // name memory
  logic [ntids_pkg::NameW-1:0] mem_q [ENTRIES];
  logic [ntids_pkg::NameW-1:0] rd_data_q;
  logic                       mem_re;
  logic [IdxW-1:0]            mem_raddr;
  logic                       mem_we;
  logic [IdxW-1:0]            mem_waddr;
  logic [ntids_pkg::NameW-1:0] mem_wdata;

  logic                       in_acc;
  ntids_pkg::op_e             op_in;
  logic [CntW-1:0]            count_m1;
  logic [CntW-1:0]            idx_m1;
  logic [CntW-1:0]            idx_nx;
  logic                       full;
  logic                       scan_match;
  logic                       scan_miss;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign op_in           = ntids_pkg::op_e'(s_axis_tuser_i);

  assign count_m1 = count_q - CntW'(1);
  assign idx_m1   = idx_q - CntW'(1);
  assign idx_nx   = idx_q + CntW'(1);
  assign full     = (count_q == CntW'(ENTRIES));

  // compare the name read last cycle against the key
  assign scan_match = pend_q && (rd_data_q == key_q);
  assign scan_miss  = pend_q && !scan_match && (idx_q == count_q);

  // memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = key_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && op_in == ntids_pkg::OP_LIST) begin
          mem_re = 1'b1;
        end
      end
      S_SCAN: begin
        if (!scan_match && idx_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q[IdxW-1:0];
        end
      end
      S_EXEC: begin
        if (op_q == ntids_pkg::OP_CREATE && !hit_q && !full) begin
          mem_we    = 1'b1;
          mem_waddr = count_q[IdxW-1:0];
        end
      end
      S_MOVE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = count_m1[IdxW-1:0];
      end
      S_MOVE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = hit_idx_q;
        mem_wdata = rd_data_q;
      end
      S_OUT: begin
        if (m_axis_tready_i && op_q == ntids_pkg::OP_LIST && !out_last_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_nx[IdxW-1:0];
        end
      end
      default: ;
    endcase
  end

  // memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  // sequencer with registered result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= ntids_pkg::OP_CREATE;
      count_q      <= '0;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ntids_pkg::ST_CREATED;
      out_name_q   <= '0;
      out_last_q   <= 1'b0;
      key_q        <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q   <= op_in;
            key_q  <= s_axis_tdata_i;
            idx_q  <= '0;
            pend_q <= 1'b0;
            hit_q  <= 1'b0;
            if (op_in == ntids_pkg::OP_LIST) begin
              if (count_q == '0) begin
                out_valid_q  <= 1'b1;
                out_status_q <= ntids_pkg::ST_EMPTY;
                out_name_q   <= '0;
                out_last_q   <= 1'b1;
                state_q      <= S_OUT;
              end else begin
                state_q <= S_LIST_WAIT;
              end
            end else if (count_q == '0) begin
              state_q <= S_EXEC;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          pend_q <= mem_re;
          if (mem_re) begin
            idx_q <= idx_nx;
          end
          if (scan_match) begin
            hit_q     <= 1'b1;
            hit_idx_q <= idx_m1[IdxW-1:0];
            state_q   <= S_EXEC;
          end else if (scan_miss) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_name_q <= '0;
          out_last_q <= 1'b1;
          unique case (op_q)
            ntids_pkg::OP_CREATE: begin
              out_valid_q <= 1'b1;
              state_q     <= S_OUT;
              if (hit_q) begin
                out_status_q <= ntids_pkg::ST_EXISTS;
              end else if (full) begin
                out_status_q <= ntids_pkg::ST_FULL;
              end else begin
                count_q      <= count_q + CntW'(1);
                out_status_q <= ntids_pkg::ST_CREATED;
              end
            end
            ntids_pkg::OP_DELETE: begin
              if (!hit_q) begin
                out_valid_q  <= 1'b1;
                out_status_q <= ntids_pkg::ST_NOTFOUND;
                state_q      <= S_OUT;
              end else if (hit_idx_q == count_m1[IdxW-1:0]) begin
                // freed slot is the last one, nothing moves
                count_q      <= count_m1;
                out_valid_q  <= 1'b1;
                out_status_q <= ntids_pkg::ST_DELETED;
                state_q      <= S_OUT;
              end else begin
                state_q <= S_MOVE_RD;
              end
            end
            ntids_pkg::OP_SEARCH: begin
              out_valid_q  <= 1'b1;
              out_status_q <= hit_q ? ntids_pkg::ST_FOUND : ntids_pkg::ST_NOTFOUND;
              state_q      <= S_OUT;
            end
            ntids_pkg::OP_LIST: begin
              state_q <= S_IDLE;
            end
          endcase
        end
        S_MOVE_RD: begin
          state_q <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          count_q      <= count_m1;
          out_valid_q  <= 1'b1;
          out_status_q <= ntids_pkg::ST_DELETED;
          out_name_q   <= '0;
          out_last_q   <= 1'b1;
          state_q      <= S_OUT;
        end
        S_LIST_WAIT: begin
          out_valid_q  <= 1'b1;
          out_status_q <= ntids_pkg::ST_LIST;
          out_name_q   <= rd_data_q;
          out_last_q   <= (idx_nx == count_q);
          state_q      <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready_i) begin
            out_valid_q <= 1'b0;
            if (op_q == ntids_pkg::OP_LIST && !out_last_q) begin
              idx_q   <= idx_nx;
              state_q <= S_LIST_WAIT;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_name_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

  // count never exceeds the table depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ENTRIES))
    else $error("entry count above table depth");

  // a new request is never taken while a result beat is pending
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("request accepted while result pending");

  // only list entries carry a name, and every other result is final
  a_name_only_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != ntids_pkg::ST_LIST)
      |-> (m_axis_tdata_o == '0 && m_axis_tlast_o))
    else $error("non-list result with name or without last");

  // count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q))
      |-> (count_q == $past(count_q) + CntW'(1) || count_q == $past(count_q) - CntW'(1)))
    else $error("entry count jumped");

  // count changes only when a create or delete result is produced
  a_count_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q))
      |-> (m_axis_tvalid_o && (m_axis_tuser_o == ntids_pkg::ST_CREATED ||
                               m_axis_tuser_o == ntids_pkg::ST_DELETED)))
    else $error("entry count changed without create or delete result");

endmodule
